>>> rtl/lwd_pkg.sv
// Shared constants, types and neighbor-step helper for the lattice walker deposition block.
package lwd_pkg;

    // Lattice geometry.
    localparam int SIDE     = 32;
    localparam int HEIGHT   = 64;
    localparam int XY_W     = $clog2(SIDE);
    localparam int Z_W      = $clog2(HEIGHT);
    localparam int ADDR_W   = 2 * XY_W + Z_W;
    localparam int NUM_DIRS = 6;

    // Field widths.
    localparam int LABEL_W = 16;
    localparam int TIME_W  = 48;
    localparam int STEP_W  = 32;
    localparam int THR_W   = 17;
    localparam int FRAC_W  = 16;
    localparam int DIR_W   = 3;
    localparam int SZ_W    = 8;
    localparam int CFG_W   = 32;

    // Request types.
    localparam logic REQ_LAUNCH = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_STICK_THRESHOLD = 1'b0;
    localparam logic CFG_TIME_STEP       = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(65536);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    // Move directions.
    localparam logic [DIR_W-1:0] DIR_ZP = 3'd0;
    localparam logic [DIR_W-1:0] DIR_ZM = 3'd1;
    localparam logic [DIR_W-1:0] DIR_YP = 3'd2;
    localparam logic [DIR_W-1:0] DIR_YM = 3'd3;
    localparam logic [DIR_W-1:0] DIR_XP = 3'd4;
    localparam logic [DIR_W-1:0] DIR_XM = 3'd5;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_WALKING   = 3'd0,
        STAT_ESCAPED   = 3'd1,
        STAT_DEPOSITED = 3'd2,
        STAT_BLOCKED   = 3'd3,
        STAT_NO_WALKER = 3'd4
    } status_t;

    // A lattice position with a flag that says whether it lies inside the lattice.
    typedef struct packed {
        logic            valid;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
    } cell_pos_t;

    // One step from (x, y, z) in direction dir; x and y wrap, z is bounded.
    function automatic cell_pos_t step_cell(
        input logic [XY_W-1:0]  x,
        input logic [XY_W-1:0]  y,
        input logic [Z_W-1:0]   z,
        input logic [DIR_W-1:0] dir
    );
        cell_pos_t r;
        r.valid = 1'b1;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        unique case (dir)
            DIR_ZP:
            begin
                if (z == Z_W'(HEIGHT - 1))
                    r.valid = 1'b0;
                else
                    r.z = z + 1'b1;
            end
            DIR_ZM:
            begin
                if (z == '0)
                    r.valid = 1'b0;
                else
                    r.z = z - 1'b1;
            end
            DIR_YP: r.y = (y == XY_W'(SIDE - 1)) ? '0 : y + 1'b1;
            DIR_YM: r.y = (y == '0) ? XY_W'(SIDE - 1) : y - 1'b1;
            DIR_XP: r.x = (x == XY_W'(SIDE - 1)) ? '0 : x + 1'b1;
            DIR_XM: r.x = (x == '0) ? XY_W'(SIDE - 1) : x - 1'b1;
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

    // Memory address of a cell: x major, then y, then z.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [XY_W-1:0] x,
        input logic [XY_W-1:0] y,
        input logic [Z_W-1:0]  z
    );
        return {x, y, z};
    endfunction

endpackage

>>> rtl/lattice_walker_deposition_top.sv
// Top level of the lattice walker deposition block: sequencer around one lattice memory.
//
// Usage: an item is taken at a rising edge where start is high and busy is low.
// A launch item (req_type 0) places a walker; a tick item (req_type 1) tries one
// move in direction move_dir. Each item gives exactly one result: done is high
// for one cycle with status, pos_x, pos_y, pos_z and elapsed_time valid. The
// receiver cannot stall; elapsed_time holds until the next item is taken.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
// only while busy is low and no result is pending. The block does not check this.
// Sequence: a tick first reads the target cell from the single-port lattice
// memory; then up to six neighbor reads are issued one per cycle, each checked
// once its registered read data is back; then one deposit write. Results with no
// memory access come back in the next cycle.
// Reset: a clearing pass writes zero into every one of the 65536 lattice cells,
// one per cycle, and busy stays high until the pass is done.
module lattice_walker_deposition_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [lwd_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  req_type,
    input  logic [lwd_pkg::XY_W-1:0]              start_x,
    input  logic [lwd_pkg::XY_W-1:0]              start_y,
    input  logic signed [lwd_pkg::SZ_W-1:0]       start_z,
    input  logic [lwd_pkg::LABEL_W-1:0]           particle_label,
    input  logic [lwd_pkg::DIR_W-1:0]             move_dir,
    input  logic [lwd_pkg::FRAC_W-1:0]            random_fraction,
    output logic                                  done,
    output logic [2:0]                            status,
    output logic [lwd_pkg::XY_W-1:0]              pos_x,
    output logic [lwd_pkg::XY_W-1:0]              pos_y,
    output logic [lwd_pkg::Z_W-1:0]               pos_z,
    output logic [lwd_pkg::TIME_W-1:0]            elapsed_time
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TGT_RD,
        S_TGT_CHK,
        S_NBR,
        S_WRITE
    } fsm_state_t;

    fsm_state_t                        state_reg;
    logic [lwd_pkg::ADDR_W-1:0]        clr_cnt_reg;

    logic [lwd_pkg::THR_W-1:0]         thr_reg;
    logic [lwd_pkg::STEP_W-1:0]        step_reg;
    logic [lwd_pkg::TIME_W-1:0]        time_reg;

    logic [lwd_pkg::XY_W-1:0]          walker_x_reg;
    logic [lwd_pkg::XY_W-1:0]          walker_y_reg;
    logic [lwd_pkg::Z_W-1:0]           walker_z_reg;
    logic                              active_reg;
    logic [lwd_pkg::LABEL_W-1:0]       label_reg;

    logic                              stick_ok_reg;
    lwd_pkg::cell_pos_t                tgt_reg;
    logic [2:0]                        nbr_idx_reg;
    logic                              pend_reg;

    logic                              done_reg;
    lwd_pkg::status_t                  status_reg;
    logic [lwd_pkg::XY_W-1:0]          pos_x_reg;
    logic [lwd_pkg::XY_W-1:0]          pos_y_reg;
    logic [lwd_pkg::Z_W-1:0]           pos_z_reg;

    // Lattice memory, single port, registered read data.
    logic [lwd_pkg::LABEL_W-1:0]       mem [0:(1 << lwd_pkg::ADDR_W)-1];
    logic [lwd_pkg::LABEL_W-1:0]       rdata_reg;
    logic [lwd_pkg::ADDR_W-1:0]        mem_addr;
    logic                              mem_we;
    logic [lwd_pkg::LABEL_W-1:0]       mem_wdata;

    logic                              accept;
    logic [lwd_pkg::TIME_W:0]          time_sum;
    logic [lwd_pkg::TIME_W-1:0]        time_sat;
    logic                              launch_z_ok;
    logic [lwd_pkg::Z_W-1:0]           launch_z;
    lwd_pkg::cell_pos_t                move_tgt;
    lwd_pkg::cell_pos_t                nbr_pos;
    logic                              nbr_found;
    logic                              nbr_last;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Saturating time accumulation for the item being taken.
    assign time_sum = {1'b0, time_reg} + (lwd_pkg::TIME_W + 1)'(step_reg);
    assign time_sat = time_sum[lwd_pkg::TIME_W] ? '1 : time_sum[lwd_pkg::TIME_W-1:0];

    // Launch height must lie inside the lattice.
    assign launch_z    = start_z[lwd_pkg::Z_W-1:0];
    assign launch_z_ok = !start_z[lwd_pkg::SZ_W-1]
        && (start_z[lwd_pkg::SZ_W-2:0] < (lwd_pkg::SZ_W - 1)'(lwd_pkg::HEIGHT));

    // Move target and the neighbor under scan.
    assign move_tgt = lwd_pkg::step_cell(walker_x_reg, walker_y_reg, walker_z_reg, move_dir);
    assign nbr_pos  = lwd_pkg::step_cell(walker_x_reg, walker_y_reg, walker_z_reg,
                                         nbr_idx_reg);
    assign nbr_found = pend_reg && (rdata_reg != '0);
    assign nbr_last  = (nbr_idx_reg == 3'(lwd_pkg::NUM_DIRS));

    // Memory port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = label_reg;
        mem_addr  = lwd_pkg::cell_addr(walker_x_reg, walker_y_reg, walker_z_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                mem_addr  = clr_cnt_reg;
            end
            S_TGT_RD:  mem_addr = lwd_pkg::cell_addr(tgt_reg.x, tgt_reg.y, tgt_reg.z);
            S_NBR:     mem_addr = lwd_pkg::cell_addr(nbr_pos.x, nbr_pos.y, nbr_pos.z);
            S_WRITE:   mem_we   = 1'b1;
            default:   mem_we   = 1'b0;
        endcase
    end

    // Lattice memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    // Sequencer with walker state and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            thr_reg      <= lwd_pkg::THR_RESET;
            step_reg     <= lwd_pkg::STEP_RESET;
            time_reg     <= '0;
            walker_x_reg <= '0;
            walker_y_reg <= '0;
            walker_z_reg <= '0;
            active_reg   <= 1'b0;
            label_reg    <= '0;
            stick_ok_reg <= 1'b0;
            tgt_reg      <= '0;
            nbr_idx_reg  <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= lwd_pkg::STAT_WALKING;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lwd_pkg::CFG_STICK_THRESHOLD: thr_reg  <= cfg_data[lwd_pkg::THR_W-1:0];
                    lwd_pkg::CFG_TIME_STEP:       step_reg <= cfg_data[lwd_pkg::STEP_W-1:0];
                    default:                      step_reg <= step_reg;
                endcase
            end

            unique case (state_reg)
                // Zero the lattice after reset.
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                        state_reg <= S_IDLE;
                end

                // Take an item and settle everything that needs no memory access.
                S_IDLE:
                begin
                    if (accept)
                    begin
                        time_reg     <= time_sat;
                        stick_ok_reg <= ({1'b0, random_fraction} < thr_reg);
                        nbr_idx_reg  <= '0;
                        pend_reg     <= 1'b0;
                        if (req_type == lwd_pkg::REQ_LAUNCH)
                        begin
                            label_reg <= particle_label;
                            if (!launch_z_ok)
                            begin
                                active_reg <= 1'b0;
                                done_reg   <= 1'b1;
                                status_reg <= lwd_pkg::STAT_ESCAPED;
                                pos_x_reg  <= '0;
                                pos_y_reg  <= '0;
                                pos_z_reg  <= '0;
                            end
                            else
                            begin
                                walker_x_reg <= start_x;
                                walker_y_reg <= start_y;
                                walker_z_reg <= launch_z;
                                active_reg   <= 1'b1;
                                if ({1'b0, random_fraction} < thr_reg)
                                    state_reg <= S_NBR;
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= lwd_pkg::STAT_WALKING;
                                    pos_x_reg  <= start_x;
                                    pos_y_reg  <= start_y;
                                    pos_z_reg  <= launch_z;
                                end
                            end
                        end
                        else if (!active_reg)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= lwd_pkg::STAT_NO_WALKER;
                            pos_x_reg  <= '0;
                            pos_y_reg  <= '0;
                            pos_z_reg  <= '0;
                        end
                        else if (move_dir >= lwd_pkg::DIR_W'(lwd_pkg::NUM_DIRS))
                        begin
                            // An unknown direction is refused in place.
                            done_reg   <= 1'b1;
                            status_reg <= lwd_pkg::STAT_BLOCKED;
                            pos_x_reg  <= walker_x_reg;
                            pos_y_reg  <= walker_y_reg;
                            pos_z_reg  <= walker_z_reg;
                        end
                        else if (!move_tgt.valid)
                        begin
                            // Stepping out of the lattice in z is an escape.
                            active_reg <= 1'b0;
                            done_reg   <= 1'b1;
                            status_reg <= lwd_pkg::STAT_ESCAPED;
                            pos_x_reg  <= '0;
                            pos_y_reg  <= '0;
                            pos_z_reg  <= '0;
                        end
                        else
                        begin
                            tgt_reg   <= move_tgt;
                            state_reg <= S_TGT_RD;
                        end
                    end
                end

                // Target cell read is in flight.
                S_TGT_RD:
                begin
                    state_reg <= S_TGT_CHK;
                end

                // Occupied target refuses the move; otherwise the walker steps.
                S_TGT_CHK:
                begin
                    if (rdata_reg != '0)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= lwd_pkg::STAT_BLOCKED;
                        pos_x_reg  <= walker_x_reg;
                        pos_y_reg  <= walker_y_reg;
                        pos_z_reg  <= walker_z_reg;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        walker_x_reg <= tgt_reg.x;
                        walker_y_reg <= tgt_reg.y;
                        walker_z_reg <= tgt_reg.z;
                        if (tgt_reg.z == '0)
                            state_reg <= S_WRITE;
                        else if (stick_ok_reg)
                            state_reg <= S_NBR;
                        else
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= lwd_pkg::STAT_WALKING;
                            pos_x_reg  <= tgt_reg.x;
                            pos_y_reg  <= tgt_reg.y;
                            pos_z_reg  <= tgt_reg.z;
                            state_reg  <= S_IDLE;
                        end
                    end
                end

                // Neighbor scan: issue one read per cycle, check the previous one.
                S_NBR:
                begin
                    pend_reg <= !nbr_last && nbr_pos.valid;
                    if (nbr_found)
                        state_reg <= S_WRITE;
                    else if (nbr_last)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= lwd_pkg::STAT_WALKING;
                        pos_x_reg  <= walker_x_reg;
                        pos_y_reg  <= walker_y_reg;
                        pos_z_reg  <= walker_z_reg;
                        state_reg  <= S_IDLE;
                    end
                    else
                        nbr_idx_reg <= nbr_idx_reg + 1'b1;
                end

                // Deposit the label into the walker's cell.
                S_WRITE:
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                    status_reg <= lwd_pkg::STAT_DEPOSITED;
                    pos_x_reg  <= walker_x_reg;
                    pos_y_reg  <= walker_y_reg;
                    pos_z_reg  <= walker_z_reg;
                    state_reg  <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign elapsed_time = time_reg;

endmodule

>>> test/tb_lattice_walker_deposition_top.sv
// Self-checking testbench for the lattice walker deposition block.
`timescale 1ns / 1ps

module tb_lattice_walker_deposition_top;

    localparam int                        CYCLE_LIMIT   = 5_000_000;
    localparam bit [lwd_pkg::TIME_W-1:0]  TIME_MAX      = '1;
    localparam int                        LATTICE_CELLS =
        lwd_pkg::SIDE * lwd_pkg::SIDE * lwd_pkg::HEIGHT;

    // One request item as seen on the input ports.
    typedef struct {
        logic                              req;
        logic [lwd_pkg::XY_W-1:0]          sx;
        logic [lwd_pkg::XY_W-1:0]          sy;
        logic signed [lwd_pkg::SZ_W-1:0]   sz;
        logic [lwd_pkg::LABEL_W-1:0]       label;
        logic [lwd_pkg::DIR_W-1:0]         dir;
        logic [lwd_pkg::FRAC_W-1:0]        frac;
    } walk_item_t;

    // One expected result.
    typedef struct {
        lwd_pkg::status_t                status;
        bit [lwd_pkg::XY_W-1:0]          x;
        bit [lwd_pkg::XY_W-1:0]          y;
        bit [lwd_pkg::Z_W-1:0]           z;
        bit [lwd_pkg::TIME_W-1:0]        elapsed;
    } walk_result_t;

    // Tracks the lattice and walker, predicts each result and checks the block against it.
    class walker_scoreboard;
        bit [lwd_pkg::LABEL_W-1:0] lattice [LATTICE_CELLS];
        bit [lwd_pkg::XY_W-1:0]    wx;
        bit [lwd_pkg::XY_W-1:0]    wy;
        bit [lwd_pkg::Z_W-1:0]     wz;
        bit                        active;
        bit [lwd_pkg::LABEL_W-1:0] label;
        bit [lwd_pkg::TIME_W-1:0]  elapsed;
        bit [lwd_pkg::THR_W-1:0]   threshold;
        bit [lwd_pkg::STEP_W-1:0]  time_step;
        walk_result_t              expected_results [$];
        int                        failures;

        function new();
            threshold = lwd_pkg::THR_RESET;
            time_step = lwd_pkg::STEP_RESET;
        endfunction

        function bit occupied(bit [lwd_pkg::XY_W-1:0] x, bit [lwd_pkg::XY_W-1:0] y,
                              bit [lwd_pkg::Z_W-1:0] z);
            return lattice[{x, y, z}] != '0;
        endfunction

        // Neighbor in direction dir; x and y wrap, z is bounded. Returns 0 if off the lattice.
        function bit move_target(input bit [lwd_pkg::XY_W-1:0] x,
                                 input bit [lwd_pkg::XY_W-1:0] y,
                                 input bit [lwd_pkg::Z_W-1:0] z,
                                 input bit [lwd_pkg::DIR_W-1:0] dir,
                                 output bit [lwd_pkg::XY_W-1:0] nx,
                                 output bit [lwd_pkg::XY_W-1:0] ny,
                                 output bit [lwd_pkg::Z_W-1:0] nz);
            int zt;
            nx = x;
            ny = y;
            nz = z;
            zt = int'(z);
            case (dir)
                lwd_pkg::DIR_ZP: zt = int'(z) + 1;
                lwd_pkg::DIR_ZM: zt = int'(z) - 1;
                lwd_pkg::DIR_YP: ny = y + 1'b1;
                lwd_pkg::DIR_YM: ny = y - 1'b1;
                lwd_pkg::DIR_XP: nx = x + 1'b1;
                lwd_pkg::DIR_XM: nx = x - 1'b1;
                default: return 1'b0;
            endcase
            if (zt < 0 || zt >= lwd_pkg::HEIGHT)
                return 1'b0;
            nz = zt[lwd_pkg::Z_W-1:0];
            return 1'b1;
        endfunction

        function bit touches_deposit(bit [lwd_pkg::XY_W-1:0] x, bit [lwd_pkg::XY_W-1:0] y,
                                     bit [lwd_pkg::Z_W-1:0] z);
            bit [lwd_pkg::XY_W-1:0] nx;
            bit [lwd_pkg::XY_W-1:0] ny;
            bit [lwd_pkg::Z_W-1:0]  nz;
            for (int d = 0; d < lwd_pkg::NUM_DIRS; d++)
            begin
                if (move_target(x, y, z, lwd_pkg::DIR_W'(d), nx, ny, nz)
                    && occupied(nx, ny, nz))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advance the lattice by one accepted item and queue its result.
        function void note_item(walk_item_t it);
            walk_result_t           r;
            bit                     stick;
            int                     zi;
            bit [lwd_pkg::XY_W-1:0] nx;
            bit [lwd_pkg::XY_W-1:0] ny;
            bit [lwd_pkg::Z_W-1:0]  nz;
            r.status = lwd_pkg::STAT_WALKING;
            r.x = '0;
            r.y = '0;
            r.z = '0;
            stick = {1'b0, it.frac} < threshold;
            if (TIME_MAX - elapsed < lwd_pkg::TIME_W'(time_step))
                elapsed = TIME_MAX;
            else
                elapsed = elapsed + lwd_pkg::TIME_W'(time_step);
            r.elapsed = elapsed;

            if (it.req == lwd_pkg::REQ_LAUNCH)
            begin
                label = it.label;
                zi = it.sz;
                if (zi < 0 || zi >= lwd_pkg::HEIGHT)
                begin
                    active = 1'b0;
                    r.status = lwd_pkg::STAT_ESCAPED;
                end
                else
                begin
                    wx = it.sx;
                    wy = it.sy;
                    wz = zi[lwd_pkg::Z_W-1:0];
                    active = 1'b1;
                    r.x = wx;
                    r.y = wy;
                    r.z = wz;
                    if (stick && touches_deposit(wx, wy, wz))
                    begin
                        lattice[{wx, wy, wz}] = label;
                        active = 1'b0;
                        r.status = lwd_pkg::STAT_DEPOSITED;
                    end
                end
            end
            else if (!active)
            begin
                r.status = lwd_pkg::STAT_NO_WALKER;
            end
            else
            begin
                r.x = wx;
                r.y = wy;
                r.z = wz;
                if (it.dir > lwd_pkg::DIR_XM)
                    r.status = lwd_pkg::STAT_BLOCKED;
                else if (!move_target(wx, wy, wz, it.dir, nx, ny, nz))
                begin
                    // Left the lattice through the floor or the ceiling.
                    active = 1'b0;
                    r.status = lwd_pkg::STAT_ESCAPED;
                    r.x = '0;
                    r.y = '0;
                    r.z = '0;
                end
                else if (occupied(nx, ny, nz))
                    r.status = lwd_pkg::STAT_BLOCKED;
                else
                begin
                    wx = nx;
                    wy = ny;
                    wz = nz;
                    r.x = nx;
                    r.y = ny;
                    r.z = nz;
                    if (nz == '0 || (stick && touches_deposit(nx, ny, nz)))
                    begin
                        lattice[{nx, ny, nz}] = label;
                        active = 1'b0;
                        r.status = lwd_pkg::STAT_DEPOSITED;
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, bit [lwd_pkg::TIME_W-1:0] want,
                                    logic [lwd_pkg::TIME_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        // Compare one strobed result against the oldest expectation.
        function void check_result(logic [2:0] st, logic [lwd_pkg::XY_W-1:0] x,
                                   logic [lwd_pkg::XY_W-1:0] y, logic [lwd_pkg::Z_W-1:0] z,
                                   logic [lwd_pkg::TIME_W-1:0] t);
            walk_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("status mismatch: expected no result, got %0h", st);
                failures++;
                return;
            end
            e = expected_results.pop_front();
            compare_field("status", lwd_pkg::TIME_W'(e.status), lwd_pkg::TIME_W'(st));
            compare_field("pos_x", lwd_pkg::TIME_W'(e.x), lwd_pkg::TIME_W'(x));
            compare_field("pos_y", lwd_pkg::TIME_W'(e.y), lwd_pkg::TIME_W'(y));
            compare_field("pos_z", lwd_pkg::TIME_W'(e.z), lwd_pkg::TIME_W'(z));
            compare_field("elapsed_time", e.elapsed, t);
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              cfg_we;
    logic                              cfg_index;
    logic [lwd_pkg::CFG_W-1:0]         cfg_data;
    logic                              req_type;
    logic [lwd_pkg::XY_W-1:0]          start_x;
    logic [lwd_pkg::XY_W-1:0]          start_y;
    logic signed [lwd_pkg::SZ_W-1:0]   start_z;
    logic [lwd_pkg::LABEL_W-1:0]       particle_label;
    logic [lwd_pkg::DIR_W-1:0]         move_dir;
    logic [lwd_pkg::FRAC_W-1:0]        random_fraction;
    logic                              done;
    logic [2:0]                        status;
    logic [lwd_pkg::XY_W-1:0]          pos_x;
    logic [lwd_pkg::XY_W-1:0]          pos_y;
    logic [lwd_pkg::Z_W-1:0]           pos_z;
    logic [lwd_pkg::TIME_W-1:0]        elapsed_time;

    walker_scoreboard sb = new();
    int               cycle_count;

    lattice_walker_deposition_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .start_x         (start_x),
        .start_y         (start_y),
        .start_z         (start_z),
        .particle_label  (particle_label),
        .move_dir        (move_dir),
        .random_fraction (random_fraction),
        .done            (done),
        .status          (status),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .elapsed_time    (elapsed_time)
    );

    // Clock: 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Monitor: check strobed results, then note any item taken at this edge.
    always @(posedge clk)
    begin : monitor
        walk_item_t seen;
        if (rst_n)
        begin
            if (done)
                sb.check_result(status, pos_x, pos_y, pos_z, elapsed_time);
            if (start && busy === 1'b0)
            begin
                seen.req   = req_type;
                seen.sx    = start_x;
                seen.sy    = start_y;
                seen.sz    = start_z;
                seen.label = particle_label;
                seen.dir   = move_dir;
                seen.frac  = random_fraction;
                sb.note_item(seen);
            end
        end
    end

    function automatic walk_item_t make_item(logic req, int x, int y, int z, int label,
                                             logic [lwd_pkg::DIR_W-1:0] dir, int frac);
        walk_item_t it;
        it.req   = req;
        it.sx    = lwd_pkg::XY_W'(x);
        it.sy    = lwd_pkg::XY_W'(y);
        it.sz    = lwd_pkg::SZ_W'(z);
        it.label = lwd_pkg::LABEL_W'(label);
        it.dir   = dir;
        it.frac  = lwd_pkg::FRAC_W'(frac);
        return it;
    endfunction

    // Anything at all, including heights far outside the lattice.
    function automatic walk_item_t noise_item();
        return make_item(1'($urandom), $urandom, $urandom, $urandom, $urandom,
                         lwd_pkg::DIR_W'($urandom), $urandom);
    endfunction

    // Launches mostly near the floor and around one wrapped corner so deposits pile up.
    function automatic walk_item_t launch_item();
        walk_item_t it;
        int         r;
        it = noise_item();
        it.req = lwd_pkg::REQ_LAUNCH;
        if ($urandom_range(0, 9) < 7)
        begin
            it.sx = lwd_pkg::XY_W'($urandom_range(0, 4) + lwd_pkg::SIDE - 2);
            it.sy = lwd_pkg::XY_W'($urandom_range(0, 4) + lwd_pkg::SIDE - 2);
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            it.sz = lwd_pkg::SZ_W'($urandom_range(0, 6));
        else if (r < 90)
            it.sz = lwd_pkg::SZ_W'($urandom_range(0, lwd_pkg::HEIGHT - 1));
        return it;
    endfunction

    // Ticks lean downward, with the occasional invalid direction.
    function automatic walk_item_t tick_item();
        walk_item_t it;
        int         r;
        it = noise_item();
        it.req = lwd_pkg::REQ_TICK;
        r = $urandom_range(0, 99);
        if (r < 30)
            it.dir = lwd_pkg::DIR_ZM;
        else if (r < 95)
            it.dir = lwd_pkg::DIR_W'($urandom_range(lwd_pkg::DIR_ZP, lwd_pkg::DIR_XM));
        else
            it.dir = lwd_pkg::DIR_XM + lwd_pkg::DIR_W'($urandom_range(1, 2));
        return it;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input walk_item_t it);
        start           <= 1'b1;
        req_type        <= it.req;
        start_x         <= it.sx;
        start_y         <= it.sy;
        start_z         <= it.sz;
        particle_label  <= it.label;
        move_dir        <= it.dir;
        random_fraction <= it.frac;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Random sender gap before the next item.
    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Stop sending and wait until every expected result is back and the block is idle.
    task automatic wait_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_results.size() != 0 || busy !== 1'b0);
    endtask

    // Write both registers; only called while the block is idle.
    task automatic program_config(input bit [lwd_pkg::THR_W-1:0] thr,
                                  input bit [lwd_pkg::STEP_W-1:0] step);
        cfg_we    <= 1'b1;
        cfg_index <= lwd_pkg::CFG_STICK_THRESHOLD;
        cfg_data  <= lwd_pkg::CFG_W'(thr);
        @(posedge clk);
        cfg_index <= lwd_pkg::CFG_TIME_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.threshold = thr;
        sb.time_step = step;
    endtask

    // Random walks: a launch and a run of ticks, with some stray items mixed in.
    task automatic run_random(input int count, input int idle_pct);
        int sent;
        int ticks;
        sent = 0;
        while (sent < count)
        begin
            sender_gap(idle_pct);
            if ($urandom_range(0, 9) == 0)
                send_item(noise_item());
            else
            begin
                send_item(launch_item());
                ticks = $urandom_range(1, 14);
                repeat (ticks)
                begin
                    sender_gap(idle_pct);
                    send_item(tick_item());
                end
                sent += ticks;
            end
            sent++;
        end
    endtask

    initial
    begin
        cycle_count     = 0;
        rst_n           = 1'b0;
        start           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= lwd_pkg::CFG_STICK_THRESHOLD;
        cfg_data        <= '0;
        req_type        <= lwd_pkg::REQ_LAUNCH;
        start_x         <= '0;
        start_y         <= '0;
        start_z         <= '0;
        particle_label  <= '0;
        move_dir        <= lwd_pkg::DIR_ZP;
        random_fraction <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walks with the reset configuration: sticking always succeeds.
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 31, 0, -128, 'hFFFF, lwd_pkg::DIR_ZP, 'hFFFF));
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 0, 31, 127, 'hFFFF, lwd_pkg::DIR_ZP, 'hFFFF));
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 7, 7, lwd_pkg::HEIGHT, 'hFFFF,
                            lwd_pkg::DIR_ZP, 0));
        // Walker at the ceiling steps up and out.
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 31, 31, lwd_pkg::HEIGHT - 1, 'hFFFF,
                            lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZP, 0));
        // Step onto the floor deposits; then launch deposits above it, twice on one cell.
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 0, 0, 1, 'h8001, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZM, 0));
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 0, 0, 1, 'h0002, lwd_pkg::DIR_ZP, 'hFFFF));
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 0, 0, 1, 'h0003, lwd_pkg::DIR_ZP, 0));
        // Invalid directions are refused, then one step in each horizontal direction.
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 10, 10, 10, 0, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_XM + 3'd1, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_XM + 3'd2, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_YP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_YM, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_XP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_XM, 0));
        // Wrap around in x and y.
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 31, 0, 20, 'h1234, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_XP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_YM, 0));

        // Never sticking, largest time step: blocked moves and a zero label.
        wait_quiet();
        program_config('0, '1);
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 0, 0, 2, 5, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZM, 0));
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 3, 3, 1, 0, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZM, 0));
        // The zero-label floor cell must still be free.
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 3, 3, 2, 7, lwd_pkg::DIR_ZP, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZM, 0));
        send_item(make_item(lwd_pkg::REQ_TICK, 0, 0, 0, 0, lwd_pkg::DIR_ZM, 0));

        // Random walks under three settings and three sender idle patterns.
        wait_quiet();
        program_config(lwd_pkg::THR_W'(32768), lwd_pkg::STEP_W'($urandom));
        run_random(320, 19);
        wait_quiet();
        program_config(lwd_pkg::THR_W'(65536), '0);
        run_random(320, 87);
        wait_quiet();
        program_config(lwd_pkg::THR_W'($urandom_range(0, 65536)), lwd_pkg::STEP_W'($urandom));
        run_random(310, 0);

        // Largest time step after an escaped launch, then walk a little more.
        wait_quiet();
        program_config(lwd_pkg::THR_W'($urandom_range(0, 65536)), '1);
        send_item(make_item(lwd_pkg::REQ_LAUNCH, 0, 0, -1, 1, lwd_pkg::DIR_ZP, 0));
        run_random(20, 0);

        wait_quiet();
        repeat (12) @(posedge clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
